@@ rtl/tmep_pkg.sv @@
package tmep_pkg;

    // event kinds
    localparam logic [3:0] KIND_INT     = 4'd0;
    localparam logic [3:0] KIND_BYTES   = 4'd1;
    localparam logic [3:0] KIND_STRING  = 4'd2;
    localparam logic [3:0] KIND_ARRAY   = 4'd3;
    localparam logic [3:0] KIND_MAP     = 4'd4;
    localparam logic [3:0] KIND_TAG     = 4'd5;
    localparam logic [3:0] KIND_SPECIAL = 4'd6;
    localparam logic [3:0] KIND_RDERR   = 4'd7;
    localparam logic [3:0] KIND_RESTART = 4'd8;

    // fixed tags
    localparam logic [32:0] TAG_REQ_WRAPPER  = 33'd1000;
    localparam logic [32:0] TAG_RESP_WRAPPER = 33'd2000;
    localparam logic [32:0] TAG_GET          = 33'd1100;
    localparam logic [32:0] TAG_GET_OK       = 33'd2100;
    localparam logic [32:0] TAG_GET_EMPTY    = 33'd2101;

    // register map
    localparam int          CFG_AW         = 4;
    localparam logic [1:0]  REG_ADD        = 2'd0;
    localparam logic [1:0]  REG_ADD_CONT   = 2'd1;
    localparam logic [1:0]  REG_ADD_OK     = 2'd2;
    localparam logic [1:0]  REG_TRAVERSE   = 2'd3;
    localparam logic [31:0] RST_ADD        = 32'd1200;
    localparam logic [31:0] RST_ADD_CONT   = 32'd1201;
    localparam logic [31:0] RST_ADD_OK     = 32'd2200;
    localparam logic [31:0] RST_TRAVERSE   = 32'd2201;

    // field codes
    localparam logic [3:0] FC_NONE       = 4'd0;
    localparam logic [3:0] FC_REQ_ID     = 4'd1;
    localparam logic [3:0] FC_GET_DB     = 4'd2;
    localparam logic [3:0] FC_GET_TBL    = 4'd3;
    localparam logic [3:0] FC_GET_PK     = 4'd4;
    localparam logic [3:0] FC_OK_KEY     = 4'd5;
    localparam logic [3:0] FC_OK_VAL     = 4'd6;
    localparam logic [3:0] FC_ADD_DB     = 4'd7;
    localparam logic [3:0] FC_ADD_TBL    = 4'd8;
    localparam logic [3:0] FC_ADD_KEY    = 4'd9;
    localparam logic [3:0] FC_ADD_VAL    = 4'd10;
    localparam logic [3:0] FC_TRV_ID     = 4'd11;
    localparam logic [3:0] FC_TRV_CIPHER = 4'd12;
    localparam logic [3:0] FC_CON_ID     = 4'd13;
    localparam logic [3:0] FC_CON_CMP    = 4'd14;

    // completed messages
    localparam logic [2:0] DONE_NONE      = 3'd0;
    localparam logic [2:0] DONE_REQ_GET   = 3'd1;
    localparam logic [2:0] DONE_GET_EMPTY = 3'd2;
    localparam logic [2:0] DONE_GET_OK    = 3'd3;
    localparam logic [2:0] DONE_REQ_ADD   = 3'd4;
    localparam logic [2:0] DONE_ADD_OK    = 3'd5;
    localparam logic [2:0] DONE_ADD_TRV   = 3'd6;
    localparam logic [2:0] DONE_ADD_CONT  = 3'd7;

    // errors
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_INTEGER     = 4'd1;
    localparam logic [3:0] ERR_BYTES       = 4'd2;
    localparam logic [3:0] ERR_STRING      = 4'd3;
    localparam logic [3:0] ERR_WRAP_SIZE   = 4'd4;
    localparam logic [3:0] ERR_ARRAY_SIZE  = 4'd5;
    localparam logic [3:0] ERR_ARRAY       = 4'd6;
    localparam logic [3:0] ERR_MAP_SIZE    = 4'd7;
    localparam logic [3:0] ERR_MAP         = 4'd8;
    localparam logic [3:0] ERR_TAG         = 4'd9;
    localparam logic [3:0] ERR_SPECIAL     = 4'd10;
    localparam logic [3:0] ERR_READER      = 4'd11;

    typedef struct packed {
        logic [31:0] tag_add;
        logic [31:0] tag_add_cont;
        logic [31:0] tag_add_ok;
        logic [31:0] tag_traverse;
    } tag_cfg_t;

    // classified event, front to back
    typedef struct packed {
        logic [3:0]  kind;
        logic [32:0] value;
        logic        v_eq0;
        logic        v_eq2;
        logic        v_eq3;
        logic        v_neg;
        logic        t_req_wrap;
        logic        t_resp_wrap;
        logic        t_get;
        logic        t_add;
        logic        t_cont;
        logic        t_get_empty;
        logic        t_get_ok;
        logic        t_add_ok;
        logic        t_traverse;
    } evt_class_t;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [2:0]  message_done;
        logic [3:0]  error_code;
        logic [31:0] request_id;
        logic [32:0] field_value;
    } result_t;

endpackage

@@ rtl/tmep_cfg.sv @@
module tmep_cfg
    import tmep_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tag_cfg_t          tags
);

    tag_cfg_t   tags_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign tags    = tags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg.tag_add      <= RST_ADD;
            tags_reg.tag_add_cont <= RST_ADD_CONT;
            tags_reg.tag_add_ok   <= RST_ADD_OK;
            tags_reg.tag_traverse <= RST_TRAVERSE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ADD:      tags_reg.tag_add      <= pwdata;
                REG_ADD_CONT: tags_reg.tag_add_cont <= pwdata;
                REG_ADD_OK:   tags_reg.tag_add_ok   <= pwdata;
                REG_TRAVERSE: tags_reg.tag_traverse <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ADD:      prdata = tags_reg.tag_add;
            REG_ADD_CONT: prdata = tags_reg.tag_add_cont;
            REG_ADD_OK:   prdata = tags_reg.tag_add_ok;
            REG_TRAVERSE: prdata = tags_reg.tag_traverse;
            default:      prdata = '0;
        endcase
    end

endmodule

@@ rtl/tmep_front.sv @@
module tmep_front
    import tmep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  event_kind,
    input  logic [32:0] event_value,
    input  tag_cfg_t    tags,
    output logic        evt_valid,
    output evt_class_t  evt_head,
    input  logic        evt_take
);

    evt_class_t cls;
    evt_class_t q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    // a tag register matches only a non-negative value with equal low bits
    function automatic logic tag_match(input logic [32:0] v, input logic [31:0] t);
        tag_match = !v[32] && (v[31:0] == t);
    endfunction

    always_comb
    begin
        cls.kind        = event_kind;
        cls.value       = event_value;
        cls.v_eq0       = (event_value == 33'd0);
        cls.v_eq2       = (event_value == 33'd2);
        cls.v_eq3       = (event_value == 33'd3);
        cls.v_neg       = event_value[32];
        cls.t_req_wrap  = (event_value == TAG_REQ_WRAPPER);
        cls.t_resp_wrap = (event_value == TAG_RESP_WRAPPER);
        cls.t_get       = (event_value == TAG_GET);
        cls.t_get_empty = (event_value == TAG_GET_EMPTY);
        cls.t_get_ok    = (event_value == TAG_GET_OK);
        cls.t_add       = tag_match(event_value, tags.tag_add);
        cls.t_cont      = tag_match(event_value, tags.tag_add_cont);
        cls.t_add_ok    = tag_match(event_value, tags.tag_add_ok);
        cls.t_traverse  = tag_match(event_value, tags.tag_traverse);
    end

    assign full      = (cnt_reg == 2'd2);
    assign evt_valid = (cnt_reg != 2'd0);
    assign evt_head  = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = evt_take && evt_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

@@ rtl/tmep_back.sv @@
module tmep_back
    import tmep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       evt_valid,
    input  evt_class_t evt_head,
    output logic       evt_take,
    output logic       empty,
    input  logic       pop,
    output result_t    res_head
);

    localparam logic [4:0] S_INIT      = 5'd0;
    localparam logic [4:0] S_RQ_ARR    = 5'd1;
    localparam logic [4:0] S_RQ_ID     = 5'd2;
    localparam logic [4:0] S_RQ_BODY   = 5'd3;
    localparam logic [4:0] S_RS_ARR    = 5'd4;
    localparam logic [4:0] S_RS_ID     = 5'd5;
    localparam logic [4:0] S_RS_BODY   = 5'd6;
    localparam logic [4:0] S_GET_ARR   = 5'd7;
    localparam logic [4:0] S_GET_DB    = 5'd8;
    localparam logic [4:0] S_GET_TBL   = 5'd9;
    localparam logic [4:0] S_GET_PK    = 5'd10;
    localparam logic [4:0] S_ADD_ARR   = 5'd11;
    localparam logic [4:0] S_ADD_DB    = 5'd12;
    localparam logic [4:0] S_ADD_TBL   = 5'd13;
    localparam logic [4:0] S_ADD_MAP   = 5'd14;
    localparam logic [4:0] S_ADD_KEY   = 5'd15;
    localparam logic [4:0] S_ADD_VAL   = 5'd16;
    localparam logic [4:0] S_CON_ARR   = 5'd17;
    localparam logic [4:0] S_CON_ID    = 5'd18;
    localparam logic [4:0] S_CON_CMP   = 5'd19;
    localparam logic [4:0] S_EMPTY_MAP = 5'd20;
    localparam logic [4:0] S_OK_MAP    = 5'd21;
    localparam logic [4:0] S_OK_KEY    = 5'd22;
    localparam logic [4:0] S_OK_VAL    = 5'd23;
    localparam logic [4:0] S_ADDOK_MAP = 5'd24;
    localparam logic [4:0] S_TRV_ARR   = 5'd25;
    localparam logic [4:0] S_TRV_ID    = 5'd26;
    localparam logic [4:0] S_TRV_BYTES = 5'd27;

    logic [4:0]  state_reg;
    logic [4:0]  state_next;
    logic [31:0] req_reg;
    logic [31:0] req_next;
    logic [31:0] pairs_reg;
    logic [31:0] pairs_next;
    logic [31:0] pairs_dec;
    logic [3:0]  fc;
    logic [2:0]  done;
    logic [3:0]  err;
    logic        echo;
    logic        fire;
    result_t     res;

    result_t     rq_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        do_pop;

    assign pairs_dec = pairs_reg - 32'd1;
    assign fire      = evt_valid && (cnt_reg != 2'd2);
    assign evt_take  = fire;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        pairs_next = pairs_reg;
        fc         = FC_NONE;
        done       = DONE_NONE;
        err        = ERR_NONE;
        echo       = 1'b0;
        unique case (evt_head.kind)
            KIND_INT:
            begin
                if (state_reg == S_RQ_ID || state_reg == S_RS_ID)
                begin
                    req_next   = evt_head.value[31:0];
                    state_next = (state_reg == S_RQ_ID) ? S_RQ_BODY : S_RS_BODY;
                    fc         = FC_REQ_ID;
                    echo       = 1'b1;
                end
                else if (state_reg == S_GET_PK)
                begin
                    fc = FC_GET_PK; done = DONE_REQ_GET; echo = 1'b1; state_next = S_INIT;
                end
                else if (state_reg == S_TRV_ID)
                begin
                    fc = FC_TRV_ID; echo = 1'b1; state_next = S_TRV_BYTES;
                end
                else if (state_reg == S_CON_ID)
                begin
                    fc = FC_CON_ID; echo = 1'b1; state_next = S_CON_CMP;
                end
                else if (state_reg == S_CON_CMP)
                begin
                    fc = FC_CON_CMP; done = DONE_ADD_CONT; echo = 1'b1; state_next = S_INIT;
                end
                else
                    err = ERR_INTEGER;
            end
            KIND_BYTES:
            begin
                if (state_reg == S_TRV_BYTES)
                begin
                    fc = FC_TRV_CIPHER; done = DONE_ADD_TRV; state_next = S_INIT;
                end
                else
                    err = ERR_BYTES;
            end
            KIND_STRING:
            begin
                if (state_reg == S_GET_DB)
                begin
                    fc = FC_GET_DB; state_next = S_GET_TBL;
                end
                else if (state_reg == S_GET_TBL)
                begin
                    fc = FC_GET_TBL; state_next = S_GET_PK;
                end
                else if (state_reg == S_OK_KEY)
                begin
                    fc = FC_OK_KEY; state_next = S_OK_VAL;
                end
                else if (state_reg == S_ADD_DB)
                begin
                    fc = FC_ADD_DB; state_next = S_ADD_TBL;
                end
                else if (state_reg == S_ADD_TBL)
                begin
                    fc = FC_ADD_TBL; state_next = S_ADD_MAP;
                end
                else if (state_reg == S_ADD_KEY)
                begin
                    fc = FC_ADD_KEY; state_next = S_ADD_VAL;
                end
                else if (state_reg == S_OK_VAL || state_reg == S_ADD_VAL)
                begin
                    fc         = (state_reg == S_OK_VAL) ? FC_OK_VAL : FC_ADD_VAL;
                    pairs_next = pairs_dec;
                    if (pairs_dec == 32'd0)
                    begin
                        done       = (state_reg == S_OK_VAL) ? DONE_GET_OK : DONE_REQ_ADD;
                        state_next = S_INIT;
                    end
                    else
                        state_next = (state_reg == S_OK_VAL) ? S_OK_KEY : S_ADD_KEY;
                end
                else
                    err = ERR_STRING;
            end
            KIND_ARRAY:
            begin
                if (state_reg == S_RQ_ARR || state_reg == S_RS_ARR)
                begin
                    if (evt_head.v_eq2)
                        state_next = (state_reg == S_RQ_ARR) ? S_RQ_ID : S_RS_ID;
                    else
                        err = ERR_WRAP_SIZE;
                end
                else if (state_reg == S_GET_ARR || state_reg == S_ADD_ARR)
                begin
                    if (evt_head.v_eq3)
                        state_next = (state_reg == S_GET_ARR) ? S_GET_DB : S_ADD_DB;
                    else
                        err = ERR_WRAP_SIZE;
                end
                else if (state_reg == S_TRV_ARR || state_reg == S_CON_ARR)
                begin
                    if (evt_head.v_eq2)
                        state_next = (state_reg == S_TRV_ARR) ? S_TRV_ID : S_CON_ID;
                    else
                        err = ERR_ARRAY_SIZE;
                end
                else
                    err = ERR_ARRAY;
            end
            KIND_MAP:
            begin
                if (state_reg == S_EMPTY_MAP || state_reg == S_ADDOK_MAP)
                begin
                    if (evt_head.v_eq0)
                    begin
                        done       = (state_reg == S_EMPTY_MAP) ? DONE_GET_EMPTY : DONE_ADD_OK;
                        state_next = S_INIT;
                    end
                    else
                        err = ERR_MAP_SIZE;
                end
                else if (state_reg == S_OK_MAP || state_reg == S_ADD_MAP)
                begin
                    if (evt_head.v_neg)
                        err = ERR_MAP_SIZE;
                    else if (evt_head.v_eq0)
                    begin
                        // empty counted map closes the message right away
                        pairs_next = 32'd0;
                        done       = (state_reg == S_OK_MAP) ? DONE_GET_OK : DONE_REQ_ADD;
                        state_next = S_INIT;
                    end
                    else
                    begin
                        pairs_next = evt_head.value[31:0];
                        state_next = (state_reg == S_OK_MAP) ? S_OK_KEY : S_ADD_KEY;
                    end
                end
                else
                    err = ERR_MAP;
            end
            KIND_TAG:
            begin
                if (state_reg == S_INIT)
                begin
                    if (evt_head.t_req_wrap)
                        state_next = S_RQ_ARR;
                    else if (evt_head.t_resp_wrap)
                        state_next = S_RS_ARR;
                    else
                        err = ERR_TAG;
                end
                else if (state_reg == S_RQ_BODY)
                begin
                    if (evt_head.t_get)
                        state_next = S_GET_ARR;
                    else if (evt_head.t_add)
                        state_next = S_ADD_ARR;
                    else if (evt_head.t_cont)
                        state_next = S_CON_ARR;
                    else
                        err = ERR_TAG;
                end
                else if (state_reg == S_RS_BODY)
                begin
                    if (evt_head.t_get_empty)
                        state_next = S_EMPTY_MAP;
                    else if (evt_head.t_get_ok)
                        state_next = S_OK_MAP;
                    else if (evt_head.t_add_ok)
                        state_next = S_ADDOK_MAP;
                    else if (evt_head.t_traverse)
                        state_next = S_TRV_ARR;
                    else
                        err = ERR_TAG;
                end
                else
                    err = ERR_TAG;
            end
            KIND_SPECIAL: err = ERR_SPECIAL;
            KIND_RDERR:   err = ERR_READER;
            KIND_RESTART: state_next = S_INIT;
            default:      ;
        endcase
    end

    always_comb
    begin
        res.field_code   = fc;
        res.message_done = done;
        res.error_code   = err;
        res.request_id   = req_next;
        res.field_value  = echo ? evt_head.value : 33'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            req_reg   <= 32'd0;
            pairs_reg <= 32'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            pairs_reg <= pairs_next;
        end
    end

    // two-entry result queue
    assign empty    = (cnt_reg == 2'd0);
    assign res_head = rq_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (fire && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!fire && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (fire)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rq_reg[wr_ptr_reg] <= res;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && err != ERR_NONE) |=> $stable(state_reg) && $stable(pairs_reg)
            && $stable(req_reg))
        else $error("state changed on error");

    a_done_init: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && done != DONE_NONE) |=> state_reg == S_INIT)
        else $error("completed message did not return to init");

    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && err != ERR_NONE) |-> (fc == FC_NONE && done == DONE_NONE && !echo))
        else $error("error item carries field or completion");
`endif

endmodule

@@ rtl/tagged_message_event_parser_top.sv @@
// Tagged message event parser.
// Input channel: decoded CBOR events (event_kind, event_value), pushed like
//   a queue write; an item is taken at an edge with push high and full low.
// Result channel: one result item per event (field_code, message_done,
//   error_code, request_id, field_value), read like a queue; the head is
//   valid while empty is low and leaves at an edge with pop high.
// Config: APB registers at 0x0/0x4/0x8/0xC hold the add, add-continue,
//   add-ok and add-traverse tag numbers; write only while the block is idle.
// Path: an accepted event waits in the event queue until the back part takes it;
//   its result is written into the result queue, and the head shows it from there.
// Throughput: one item per cycle while the result queue has room; the grammar
//   register updates once per item in the back part, which is the only serial loop.
// Front part classifies each event (size and tag compares) into a 2-entry
//   queue; back part walks the grammar into a 2-entry result queue.
// Reset: queues empty, grammar at init, request id and pair count zero,
//   tag registers at their defaults.
// Stall: when pop stays low the result queue fills, then the event queue,
//   and full rises after at most four items in flight; nothing is dropped.
module tagged_message_event_parser_top
    import tmep_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // event input
    input  logic              push,
    output logic              full,
    input  logic [3:0]        event_kind,
    input  logic [32:0]       event_value,
    // result output
    output logic              empty,
    input  logic              pop,
    output logic [3:0]        field_code,
    output logic [2:0]        message_done,
    output logic [3:0]        error_code,
    output logic [31:0]       request_id,
    output logic [32:0]       field_value,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    tag_cfg_t   tags;
    evt_class_t evt_head;
    logic       evt_valid;
    logic       evt_take;
    result_t    res_head;

    tmep_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tags    (tags)
    );

    // classification and event queue
    tmep_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .event_kind  (event_kind),
        .event_value (event_value),
        .tags        (tags),
        .evt_valid   (evt_valid),
        .evt_head    (evt_head),
        .evt_take    (evt_take)
    );

    // grammar walk and result queue
    tmep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_head  (evt_head),
        .evt_take  (evt_take),
        .empty     (empty),
        .pop       (pop),
        .res_head  (res_head)
    );

    assign field_code   = res_head.field_code;
    assign message_done = res_head.message_done;
    assign error_code   = res_head.error_code;
    assign request_id   = res_head.request_id;
    assign field_value  = res_head.field_value;

endmodule
